// File: rtl/kpe_pkg.sv
// Shared types and constants for the keypad password entry controller.
package kpe_pkg;

	localparam int unsigned MAX_DIGITS_DEF = 16;
	localparam int unsigned MIN_W          = 5;
	localparam logic [MIN_W-1:0] MIN_DIGITS_RST = 5'd4;

	localparam logic [7:0] KEY_DIGIT_MAX = 8'd9;
	localparam logic [7:0] KEY_ENTER     = 8'd13;
	localparam logic [7:0] KEY_PLUS      = 8'd43;
	localparam logic [7:0] KEY_MINUS     = 8'd45;

	localparam logic [7:0] BYTE_OPEN     = 8'd97;
	localparam logic [7:0] BYTE_MISMATCH = 8'd98;
	localparam logic [7:0] BYTE_TAKEN    = 8'd99;

	typedef enum logic [2:0] {
		SCR_ECHO    = 3'd0,
		SCR_NEW     = 3'd1,
		SCR_REENTER = 3'd2,
		SCR_MENU    = 3'd3,
		SCR_ROTATE  = 3'd4,
		SCR_NONE    = 3'd5
	} screen_t;

	typedef struct packed {
		logic       send_valid;
		logic [7:0] send_byte;
		screen_t    screen_event;
		logic [7:0] echo_value;
		logic       overflow_flag;
	} kpe_result_t;

endpackage

// File: rtl/kpe_ctrl.sv
// Entry and confirm state, digit memory and per-word decision logic.
module kpe_ctrl #(
	parameter int unsigned MAX_DIGITS = kpe_pkg::MAX_DIGITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic [7:0]                   key,
	input  logic [kpe_pkg::MIN_W-1:0]    min_digits,
	output kpe_pkg::kpe_result_t         result
);
	import kpe_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_DIGITS);
	localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int unsigned CMP_W = (CNT_W > MIN_W) ? CNT_W : MIN_W;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);

	logic [3:0]       mem [MAX_DIGITS];
	logic [3:0]       expect_q;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [IDX_W-1:0] mi_q, mi_d;
	logic             phase_q, phase_d;

	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [3:0]       wdata;
	logic [CNT_W-1:0] mi_inc;
	logic [MIN_W-1:0] need;
	logic             match_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			mi_q    <= '0;
			phase_q <= 1'b0;
		end else begin
			cnt_q   <= cnt_d;
			mi_q    <= mi_d;
			phase_q <= phase_d;
		end
	end

	// The expected digit is always fetched for the next match position, with the
	// word being written forwarded when it lands on the same entry.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (we && (waddr == mi_d)) begin
			expect_q <= wdata;
		end else begin
			expect_q <= mem[mi_d];
		end
	end

	always_comb begin
		cnt_d    = cnt_q;
		mi_d     = mi_q;
		phase_d  = phase_q;
		we       = 1'b0;
		waddr    = cnt_q[IDX_W-1:0];
		wdata    = key[3:0];
		mi_inc   = CNT_W'(mi_q) + CNT_W'(1);
		need     = (min_digits == '0) ? MIN_W'(1) : min_digits;
		match_ok = (CNT_W'(mi_q) < cnt_q) && (key == {4'b0000, expect_q});
		result   = '{send_valid: 1'b0, send_byte: 8'd0, screen_event: SCR_NONE,
			echo_value: 8'd0, overflow_flag: 1'b0};

		if (fire) begin
			if (phase_q) begin
				if (match_ok) begin
					if (mi_inc >= cnt_q) begin
						result.screen_event = SCR_MENU;
						phase_d = 1'b0;
						mi_d    = '0;
					end else begin
						result.screen_event = SCR_ECHO;
						result.echo_value   = key;
						mi_d = mi_inc[IDX_W-1:0];
					end
				end else begin
					cnt_d   = '0;
					mi_d    = '0;
					phase_d = 1'b0;
					result.send_valid   = 1'b1;
					result.send_byte    = BYTE_MISMATCH;
					result.screen_event = SCR_NEW;
				end
			end else if (key <= KEY_DIGIT_MAX) begin
				if (cnt_q < CNT_MAX) begin
					we    = 1'b1;
					cnt_d = cnt_q + CNT_W'(1);
					result.send_valid   = 1'b1;
					result.send_byte    = BYTE_TAKEN;
					result.screen_event = SCR_ECHO;
					result.echo_value   = key;
				end else begin
					result.overflow_flag = 1'b1;
				end
			end else if (key == KEY_ENTER) begin
				if (CMP_W'(cnt_q) >= CMP_W'(need)) begin
					phase_d = 1'b1;
					mi_d    = '0;
					result.screen_event = SCR_REENTER;
				end else begin
					cnt_d   = '0;
					mi_d    = '0;
					phase_d = 1'b0;
					result.screen_event = SCR_NEW;
				end
			end else if (key == KEY_MINUS) begin
				cnt_d   = '0;
				mi_d    = '0;
				phase_d = 1'b0;
				result.screen_event = SCR_NEW;
			end else if (key == KEY_PLUS) begin
				result.send_valid   = 1'b1;
				result.send_byte    = BYTE_OPEN;
				result.screen_event = SCR_ROTATE;
			end else begin
				result.screen_event = SCR_ECHO;
				result.echo_value   = key;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_confirm_idx: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (CNT_W'(mi_q) < cnt_q))
		else $error("match position not below digit count in confirm phase");
	a_entry_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!phase_q |-> (mi_q == '0))
		else $error("match position not cleared in entry phase");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("digit count beyond store size");
`endif

endmodule

// File: rtl/keypad_password_entry_controller_top.sv
// Top level of the keypad password entry controller with its word registers.
// A word accepted into the input register is decided and its result loaded into the output register,
// where it waits to be taken; the word waits in the input register while an untaken result is stalled.
// Throughput: one word per cycle through the single decision stage while out_stall is low.
// Reset (arst_n, asynchronous, active low) clears the valid flags, the entry state
// and sets the minimum digit count to four; the digit memory is not cleared.
module keypad_password_entry_controller_top #(
	parameter int unsigned MAX_DIGITS = kpe_pkg::MAX_DIGITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [kpe_pkg::MIN_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                key_code,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      send_valid,
	output logic [7:0]                send_byte,
	output logic [2:0]                screen_event,
	output logic [7:0]                echo_value,
	output logic                      overflow_flag
);
	import kpe_pkg::*;

	// The user must write the minimum digit count only while the block is idle; the block does not enforce it.
	logic [MIN_W-1:0] min_digits_q;

	// Input register: the word waiting to be decided.
	logic       valid_s1;
	logic [7:0] key_s1;

	// Output register: the decided result waiting to be taken.
	logic        out_valid_q;
	kpe_result_t res_q;
	kpe_result_t res_d;

	// A word is decided when the output register is empty or is being emptied
	// in the same cycle; the input register is then free to take another word.
	logic advance;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_digits_q <= MIN_DIGITS_RST;
		end else if (cfg_wr_en) begin
			min_digits_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			key_s1 <= key_code;
		end
	end

	// The decision logic holds the entry state and the digit memory.
	kpe_ctrl #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.key       (key_s1),
		.min_digits(min_digits_q),
		.result    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign send_valid    = res_q.send_valid;
	assign send_byte     = res_q.send_byte;
	assign screen_event  = res_q.screen_event;
	assign echo_value    = res_q.echo_value;
	assign overflow_flag = res_q.overflow_flag;

`ifndef NO_ASSERTIONS
	a_advance_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("decided word did not reach the output register");
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");
`endif

endmodule
